// ----- sv/sls_pkg.sv -----
// ----------------------------------------------------------------------------
// sls_pkg - skip list set engine shared definitions
// Command codes, field widths and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package sls_pkg;

  localparam int MAX_LEVELS_DEF = 16;
  localparam int POOL_NODES_DEF = 1024;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int LVLF_W  = 5;
  localparam int CFG_W   = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [KEY_W-1:0] KEY_MAX   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONTAINS = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

endpackage
`default_nettype wire

// ----- sv/skip_list_set_engine_unit.sv -----
// Operation: the search walks down L levels and steps past V nodes; each step
//   reads a node key, then its link. An add then links the new node at each of
//   its levels, after popping it off the free list when it comes from there;
//   a remove reads the node level, unlinks it and frees it. The result is then posted.
// Throughput: one request at a time; the next request is taken once the
//   sequencer is back to idle, after the result has gone into the output register.
// Reset: synchronous; head links point to the tail, free list empty, pool
//   counter zero, levels register 16. Node memories are not cleared.
// ----------------------------------------------------------------------------
// skip_list_set_engine_unit - skip list sorted set of 32-bit keys
// Sequencer walking a node pool in RAM for contains, add and remove.
// ----------------------------------------------------------------------------
`default_nettype none
module skip_list_set_engine_unit #(
  parameter int MAX_LEVELS = sls_pkg::MAX_LEVELS_DEF,
  parameter int POOL_NODES = sls_pkg::POOL_NODES_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // levels-in-use register write
  input  wire                              cfg_wen,
  input  wire [sls_pkg::CFG_W-1:0]         cfg_wdata,
  // request: [1:0] command, [33:2] key, [38:34] node_level, [39] zero
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [sls_pkg::IN_TDATA_W-1:0]    s_tdata,
  // result: [0] success, [1] pool_empty, [7:2] zero
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [sls_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import sls_pkg::*;

  localparam int ID_W   = $clog2(POOL_NODES + 2);   // node ids incl. tail, head
  localparam int IDX_W  = $clog2(POOL_NODES);       // pool index
  localparam int CNT_W  = $clog2(POOL_NODES + 1);   // fresh node counter
  localparam int LV_W   = $clog2(MAX_LEVELS);       // level index
  localparam int LC_W   = $clog2(MAX_LEVELS + 1);   // level count
  localparam int LINK_DEPTH = (1 << IDX_W) << LV_W;
  localparam int LA_W   = IDX_W + LV_W;

  localparam logic [ID_W-1:0]  TAIL_ID = ID_W'(POOL_NODES);
  localparam logic [ID_W-1:0]  HEAD_ID = ID_W'(POOL_NODES + 1);
  localparam logic [LC_W-1:0]  LC_MAX  = LC_W'(MAX_LEVELS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(POOL_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_LVL, S_LINKW, S_CUR, S_KEYW, S_DECIDE, S_FREEW, S_ALLOC,
    S_ADDA, S_ADDB, S_RLVW, S_RCHK, S_RLNKW, S_RFREE, S_DONE
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  cfg_levels;
  cmd_t              cmd;
  logic [KEY_W-1:0]  key;
  logic [LVLF_W-1:0] req_lvl;
  logic [LC_W-1:0]   top;
  logic [LC_W-1:0]   lv;
  logic [LC_W-1:0]   lvl;
  logic [ID_W-1:0]   prev;
  logic [ID_W-1:0]   cur;
  logic [ID_W-1:0]   node;
  logic              eq;
  logic [ID_W-1:0]   free_head;
  logic [CNT_W-1:0]  unused;
  logic [ID_W-1:0]   head_links [MAX_LEVELS];
  logic [ID_W-1:0]   pred [MAX_LEVELS];
  logic [ID_W-1:0]   succ [MAX_LEVELS];
  logic              res_success;
  logic              res_empty;

  // decoded request and clamps
  cmd_t              in_cmd;
  logic [KEY_W-1:0]  in_key;
  logic [LVLF_W-1:0] in_lvl;
  logic [LC_W-1:0]   cfg_top;
  logic [LC_W-1:0]   add_lvl;
  logic [LC_W-1:0]   lv_m1;
  logic [LV_W-1:0]   lvi;
  logic [LV_W-1:0]   lvi_m1;

  // memory controls
  logic              key_we;
  logic [IDX_W-1:0]  key_waddr;
  logic [IDX_W-1:0]  key_raddr;
  logic [KEY_W-1:0]  key_rdata;
  logic              lvl_we;
  logic [LC_W-1:0]   lvl_rdata;
  logic [IDX_W-1:0]  lvl_raddr;
  logic              link_we;
  logic [LA_W-1:0]   link_waddr;
  logic [ID_W-1:0]   link_wdata;
  logic [LA_W-1:0]   link_raddr;
  logic [ID_W-1:0]   link_rdata;

  assign in_cmd = cmd_t'(s_tdata[1:0]);
  assign in_key = s_tdata[33:2];
  assign in_lvl = s_tdata[38:34];
  assign s_tready = (state == S_IDLE);

  assign lv_m1  = lv - LC_W'(1);
  assign lvi    = lv[LV_W-1:0];
  assign lvi_m1 = lv_m1[LV_W-1:0];

  // levels register: zero acts as one, above the maximum as the maximum
  always_comb begin
    if (cfg_levels == '0) begin
      cfg_top = LC_W'(1);
    end else if (7'(cfg_levels) > 7'(MAX_LEVELS)) begin
      cfg_top = LC_MAX;
    end else begin
      cfg_top = LC_W'(cfg_levels);
    end
  end

  // level of a new node, clamped to 1..top
  always_comb begin
    if (req_lvl == '0) begin
      add_lvl = LC_W'(1);
    end else if (7'(req_lvl) > 7'(top)) begin
      add_lvl = top;
    end else begin
      add_lvl = LC_W'(req_lvl);
    end
  end

  // memory port steering
  always_comb begin
    key_we     = 1'b0;
    key_waddr  = node[IDX_W-1:0];
    key_raddr  = cur[IDX_W-1:0];
    lvl_we     = 1'b0;
    lvl_raddr  = succ[0][IDX_W-1:0];
    link_we    = 1'b0;
    link_waddr = {node[IDX_W-1:0], lvi};
    link_wdata = succ[lvi];
    link_raddr = {prev[IDX_W-1:0], lvi_m1};
    case (state)
      S_LVL: begin
        link_raddr = {prev[IDX_W-1:0], lvi_m1};
      end
      S_KEYW: begin
        link_raddr = {cur[IDX_W-1:0], lvi};
      end
      S_DECIDE: begin
        link_raddr = {free_head[IDX_W-1:0], LV_W'(0)};
      end
      S_ALLOC: begin
        key_we = 1'b1;
        lvl_we = 1'b1;
      end
      S_ADDA: begin
        link_we = (lv != lvl);
      end
      S_ADDB: begin
        link_we    = (pred[lvi] != HEAD_ID);
        link_waddr = {pred[lvi][IDX_W-1:0], lvi};
        link_wdata = node;
      end
      S_RCHK: begin
        link_raddr = {node[IDX_W-1:0], lvi};
      end
      S_RLNKW: begin
        link_we    = (pred[lvi] != HEAD_ID);
        link_waddr = {pred[lvi][IDX_W-1:0], lvi};
        link_wdata = link_rdata;
      end
      S_RFREE: begin
        link_we    = 1'b1;
        link_waddr = {node[IDX_W-1:0], LV_W'(0)};
        link_wdata = free_head;
      end
      default: begin
      end
    endcase
  end

  sls_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  sls_ram #(.WIDTH(LC_W), .DEPTH(POOL_NODES)) u_levels (
    .clk(clk), .we(lvl_we), .waddr(key_waddr), .wdata(add_lvl),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  sls_ram #(.WIDTH(ID_W), .DEPTH(LINK_DEPTH)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cfg_levels <= CFG_RESET;
      free_head  <= TAIL_ID;
      unused     <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_links[i] <= TAIL_ID;
      end
    end else begin
      if (cfg_wen) begin
        cfg_levels <= cfg_wdata;
      end
      // drop the result once taken, unless a new one is posted this cycle
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd         <= in_cmd;
            key         <= in_key;
            req_lvl     <= in_lvl;
            prev        <= HEAD_ID;
            eq          <= 1'b0;
            res_success <= 1'b0;
            res_empty   <= 1'b0;
            // remove always walks every level
            top <= (in_cmd == CMD_REMOVE) ? LC_MAX : cfg_top;
            lv  <= (in_cmd == CMD_REMOVE) ? LC_MAX : cfg_top;
            state <= (in_cmd == CMD_NONE) ? S_DONE : S_LVL;
          end
        end
        // drop one level; the head's links live in flops
        S_LVL: begin
          if (lv == '0) begin
            state <= S_DECIDE;
          end else begin
            lv <= lv_m1;
            if (prev == HEAD_ID) begin
              cur   <= head_links[lvi_m1];
              state <= S_CUR;
            end else begin
              state <= S_LINKW;
            end
          end
        end
        S_LINKW: begin
          cur   <= link_rdata;
          state <= S_CUR;
        end
        S_CUR: begin
          if (cur >= TAIL_ID) begin
            pred[lvi] <= prev;
            succ[lvi] <= cur;
            eq        <= 1'b0;
            state     <= S_LVL;
          end else begin
            state <= S_KEYW;
          end
        end
        // advance along the level while the node key is smaller
        S_KEYW: begin
          if (key > key_rdata) begin
            prev  <= cur;
            state <= S_LINKW;
          end else begin
            pred[lvi] <= prev;
            succ[lvi] <= cur;
            eq        <= (key == key_rdata);
            state     <= S_LVL;
          end
        end
        S_DECIDE: begin
          lv <= '0;
          case (cmd)
            CMD_CONTAINS: begin
              res_success <= eq;
              state       <= S_DONE;
            end
            CMD_ADD: begin
              if (eq || key == KEY_MAX) begin
                state <= S_DONE;
              end else if (free_head < TAIL_ID) begin
                node  <= free_head;
                state <= S_FREEW;
              end else if (unused < CNT_MAX) begin
                node   <= ID_W'(unused);
                unused <= unused + CNT_W'(1);
                state  <= S_ALLOC;
              end else begin
                res_empty <= 1'b1;
                state     <= S_DONE;
              end
            end
            CMD_REMOVE: begin
              node  <= succ[0];
              state <= eq ? S_RLVW : S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        // pop the free list
        S_FREEW: begin
          free_head <= link_rdata;
          state     <= S_ALLOC;
        end
        S_ALLOC: begin
          lvl   <= add_lvl;
          lv    <= '0;
          state <= S_ADDA;
        end
        S_ADDA: begin
          if (lv == lvl) begin
            res_success <= 1'b1;
            state       <= S_DONE;
          end else begin
            state <= S_ADDB;
          end
        end
        S_ADDB: begin
          if (pred[lvi] == HEAD_ID) begin
            head_links[lvi] <= node;
          end
          lv    <= lv + LC_W'(1);
          state <= S_ADDA;
        end
        S_RLVW: begin
          lvl   <= lvl_rdata;
          state <= S_RCHK;
        end
        S_RCHK: begin
          if (lv == lvl) begin
            state <= S_RFREE;
          end else if (succ[lvi] == node) begin
            state <= S_RLNKW;
          end else begin
            lv <= lv + LC_W'(1);
          end
        end
        // splice the predecessor past the removed node
        S_RLNKW: begin
          if (pred[lvi] == HEAD_ID) begin
            head_links[lvi] <= link_rdata;
          end
          lv    <= lv + LC_W'(1);
          state <= S_RCHK;
        end
        S_RFREE: begin
          free_head   <= node;
          res_success <= 1'b1;
          state       <= S_DONE;
        end
        // hold the result until the output register is free
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, res_empty, res_success};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_free_allocated: assert property (@(posedge clk) disable iff (rst)
    (free_head != TAIL_ID) |-> (free_head < ID_W'(unused)))
    else $error("free list head is not an allocated node");
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    unused <= CNT_MAX)
    else $error("fresh node counter overran the pool");
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("success and pool_empty both set");
  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && s_tvalid && in_cmd != CMD_NONE) |=> (state == S_LVL))
    else $error("accepted request did not start a search");
`endif

endmodule
`default_nettype wire

// ----- sv/sls_ram.sv -----
// ----------------------------------------------------------------------------
// sls_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
